FILE: src/etdq_pkg.sv
// Shared types and constants for the transfer descriptor queue.
`timescale 1ns / 1ps
`default_nettype none
package etdq_pkg;
  localparam int unsigned Descriptors = 16;
  localparam int unsigned Endpoints = 8;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned DW = $clog2(Descriptors + 1);
  localparam int unsigned DIW = $clog2(Descriptors);
  localparam int unsigned EW = $clog2(Endpoints);
  localparam logic [DW-1:0] EndMark = DW'(Descriptors);

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpStatus = 2'd1,
    OpComplete = 2'd2,
    OpFlush = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KindEnqueue = 2'd0,
    KindRetired = 2'd1,
    KindNone = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] endpoint;
    logic [3:0] descriptor;
    logic [14:0] length;
    logic [31:0] buffer_address;
    logic [7:0] callback_tag;
    logic [14:0] remaining;
    logic active;
  } cmd_t;
endpackage
`default_nettype wire

FILE: src/etdq_front.sv
// Front end: latch commands, drop those out of range, feed the command queue.
`timescale 1ns / 1ps
`default_nettype none
module etdq_front import etdq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  cmd_t      cmd_i,
  output logic      busy_o,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_pop_i
);
  // two-entry queue
  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic keep;
  logic push;

  always_comb begin
    keep = 1'b1;
    if (cmd_i.op == OpStatus) begin
      if (32'(cmd_i.descriptor) >= Descriptors) keep = 1'b0;
    end else if (32'(cmd_i.endpoint) >= Endpoints) begin
      keep = 1'b0;
    end
  end

  assign busy_o = (cnt_q == 2'd2);
  assign push = start_i && !busy_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_i |-> cmd_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |-> cmd_valid_o)
    else $error("busy with empty queue");
endmodule
`default_nettype wire

FILE: src/etdq_back.sv
// Back end: descriptor pool, endpoint queues and the retire/flush walk.
`timescale 1ns / 1ps
`default_nettype none
module etdq_back import etdq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             valid_o,
  output logic [1:0]       kind_o,
  output logic             status_o,
  output logic [3:0]       index_out_o,
  output logic [31:0]      token_o,
  output logic [31:0]      first_page_o,
  output logic [31:0]      prime_mask_o,
  output logic [14:0]      actual_length_o,
  output logic [7:0]       tag_out_o,
  output logic [2:0]       endpoint_out_o,
  output logic             last_o
);
  typedef enum logic [1:0] {
    StIdle,
    StWalk
  } state_e;

  state_e state_q;
  logic [DW-1:0] free_head_q;
  logic [DW-1:0] link_q [Descriptors];
  logic [DW-1:0] head_q [Endpoints];
  logic [DW-1:0] tail_q [Endpoints];
  logic [14:0] len_q [Descriptors];
  logic [7:0] tag_q [Descriptors];
  logic [14:0] rem_q [Descriptors];
  logic act_q [Descriptors];
  logic [$clog2(MaxResults+1)-1:0] n_q;
  logic [$clog2(Descriptors+1)-1:0] guard_q;
  logic flush_q;

  logic [EW-1:0] ep;
  logic [DW-1:0] hd, fd;
  logic [DIW-1:0] hi, fi, ti;
  assign ep = cmd_i.endpoint[EW-1:0];
  assign hd = head_q[ep];
  assign hi = hd[DIW-1:0];
  assign fd = free_head_q;
  assign fi = fd[DIW-1:0];
  assign ti = tail_q[ep][DIW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i && !cmd_pop_o) begin
      if (cmd_i.op == OpStatus) begin
        rem_q[cmd_i.descriptor[DIW-1:0]] <= cmd_i.remaining;
        act_q[cmd_i.descriptor[DIW-1:0]] <= cmd_i.active;
      end else if (cmd_i.op == OpEnqueue && fd != EndMark) begin
        len_q[fi] <= cmd_i.length;
        tag_q[fi] <= cmd_i.callback_tag;
        rem_q[fi] <= cmd_i.length;
        act_q[fi] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      free_head_q <= '0;
      for (int i = 0; i < Descriptors; i++) link_q[i] <= DW'(i + 1);
      for (int i = 0; i < Endpoints; i++) begin
        head_q[i] <= EndMark;
        tail_q[i] <= EndMark;
      end
      n_q <= '0;
      guard_q <= '0;
      flush_q <= 1'b0;
      cmd_pop_o <= 1'b0;
      valid_o <= 1'b0;
      kind_o <= '0;
      status_o <= 1'b0;
      index_out_o <= '0;
      token_o <= '0;
      first_page_o <= '0;
      prime_mask_o <= '0;
      actual_length_o <= '0;
      tag_out_o <= '0;
      endpoint_out_o <= '0;
      last_o <= 1'b0;
    end else begin
      cmd_pop_o <= 1'b0;
      valid_o <= 1'b0;
      kind_o <= KindEnqueue;
      status_o <= 1'b0;
      index_out_o <= '0;
      token_o <= '0;
      first_page_o <= '0;
      prime_mask_o <= '0;
      actual_length_o <= '0;
      tag_out_o <= '0;
      endpoint_out_o <= cmd_i.endpoint;
      last_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i && !cmd_pop_o) begin
            unique case (cmd_i.op)
              OpStatus: cmd_pop_o <= 1'b1;
              OpEnqueue: begin
                cmd_pop_o <= 1'b1;
                valid_o <= 1'b1;
                last_o <= 1'b1;
                if (fd == EndMark) begin
                  status_o <= 1'b1;
                end else begin
                  free_head_q <= link_q[fi];
                  link_q[fi] <= EndMark;
                  if (tail_q[ep] != EndMark) link_q[ti] <= fd;
                  else head_q[ep] <= fd;
                  tail_q[ep] <= fd;
                  index_out_o <= 4'(fd);
                  token_o <= {1'b0, cmd_i.length, 16'h8080};
                  first_page_o <= {cmd_i.buffer_address[31:12], 12'h0} + 32'h1000;
                  prime_mask_o <= 32'(1) << ({2'b0, cmd_i.endpoint[2:1]}
                                  + (cmd_i.endpoint[0] ? 5'd16 : 5'd0));
                end
              end
              default: begin
                state_q <= StWalk;
                flush_q <= (cmd_i.op == OpFlush);
                n_q <= '0;
                guard_q <= '0;
              end
            endcase
          end
        end
        StWalk: begin
          if (flush_q) begin
            if (guard_q < ($clog2(Descriptors+1))'(Descriptors) && hd != EndMark) begin
              head_q[ep] <= link_q[hi];
              link_q[hi] <= free_head_q;
              free_head_q <= hd;
              guard_q <= guard_q + 1'b1;
            end else begin
              head_q[ep] <= EndMark;
              tail_q[ep] <= EndMark;
              state_q <= StIdle;
              cmd_pop_o <= 1'b1;
            end
          end else if (32'(n_q) < MaxResults && hd != EndMark && !act_q[hi]) begin
            // retire head; last is set when the next step would stop
            head_q[ep] <= link_q[hi];
            link_q[hi] <= free_head_q;
            free_head_q <= hd;
            n_q <= n_q + 1'b1;
            valid_o <= 1'b1;
            kind_o <= KindRetired;
            index_out_o <= 4'(hd);
            actual_length_o <= (len_q[hi] > rem_q[hi]) ? len_q[hi] - rem_q[hi] : '0;
            tag_out_o <= tag_q[hi];
            if (32'(n_q) + 1 >= MaxResults || link_q[hi] == EndMark
                || !(link_q[hi] == hd) && act_q[link_q[hi][DIW-1:0]]) begin
              last_o <= 1'b1;
              state_q <= StIdle;
              cmd_pop_o <= 1'b1;
              if (link_q[hi] == EndMark) tail_q[ep] <= EndMark;
            end
          end else begin
            if (hd == EndMark) tail_q[ep] <= EndMark;
            valid_o <= 1'b1;
            kind_o <= KindNone;
            last_o <= 1'b1;
            state_q <= StIdle;
            cmd_pop_o <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KindEnqueue |-> last_o)
    else $error("enqueue answer without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> index_out_o == 4'd0)
    else $error("no-free answer carries index");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> !cmd_pop_o)
    else $error("double pop");
endmodule
`default_nettype wire

FILE: src/endpoint_transfer_descriptor_queue_top.sv
// Top level of the endpoint transfer descriptor queue.
`timescale 1ns / 1ps
`default_nettype none
// A command word is taken when start_i is high and busy_o low; a two-word
// queue decouples the command front from the descriptor back end, so up to
// two words wait while the back end works. The back end dispatches the word
// at the queue head at the edge after it arrives there, and pops it at the
// edge after its final step. With the queue empty, an enqueue answer is
// registered at the edge after the one that takes the word; an enqueue or a
// status write (which gives nothing) is popped right after its dispatch.
// A completion is dispatched, then walks the endpoint queue one descriptor
// per cycle and strobes one word per retired descriptor (at least one word,
// last_o on the final), then is popped. Flush walks the queue likewise but
// gives no words, frees each descriptor and is popped. Results appear for
// one cycle under valid_o; the receiver cannot stall them.
module endpoint_transfer_descriptor_queue_top import etdq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [2:0]  endpoint_i,
  input  wire logic [3:0]  descriptor_i,
  input  wire logic [14:0] length_i,
  input  wire logic [31:0] buffer_address_i,
  input  wire logic [7:0]  callback_tag_i,
  input  wire logic [14:0] remaining_i,
  input  wire logic        active_i,
  output logic             valid_o,
  output logic [1:0]       kind_o,
  output logic             status_o,
  output logic [3:0]       index_out_o,
  output logic [31:0]      token_o,
  output logic [31:0]      first_page_o,
  output logic [31:0]      prime_mask_o,
  output logic [14:0]      actual_length_o,
  output logic [7:0]       tag_out_o,
  output logic [2:0]       endpoint_out_o,
  output logic             last_o
);
  cmd_t cmd_in, cmd_q;
  logic cmd_valid, cmd_pop;

  assign cmd_in = '{op: op_i, endpoint: endpoint_i, descriptor: descriptor_i,
                    length: length_i, buffer_address: buffer_address_i,
                    callback_tag: callback_tag_i, remaining: remaining_i,
                    active: active_i};

  etdq_front u_front (
    .clk_i, .rst_ni, .start_i, .cmd_i(cmd_in), .busy_o,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd_q), .cmd_pop_i(cmd_pop)
  );

  etdq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd_q), .cmd_pop_o(cmd_pop),
    .valid_o, .kind_o, .status_o, .index_out_o, .token_o, .first_page_o,
    .prime_mask_o, .actual_length_o, .tag_out_o, .endpoint_out_o, .last_o
  );
endmodule
`default_nettype wire
